// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ----- design/msc_pkg.sv -----
// Package: widths, constants and helpers for the microphone capture block.
package msc_pkg;

  localparam int unsigned PosW    = 12;
  localparam int unsigned LenW    = 13;
  localparam int unsigned BufW    = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [LenW-1:0] MaxBlock = 13'd4096;
  localparam logic [LenW-1:0] PosSpan  = 13'd4096;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgSampleMode  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBlockLength = 1'b1;

  localparam logic [BufW-1:0] LastBuf = 2'd2;

  // saturation bounds on the offset-removed codes
  localparam logic signed [7:0]  Sat8Hi  = 8'sd31;
  localparam logic signed [7:0]  Sat8Lo  = -8'sd32;
  localparam logic signed [11:0] Sat12Hi = 12'sd511;
  localparam logic signed [11:0] Sat12Lo = -12'sd512;

  localparam logic [ByteW-1:0]   U8Max  = 8'hFF;
  localparam logic [ByteW-1:0]   U8Min  = 8'h00;
  localparam logic [SampleW-1:0] S16Max = 16'h7FFF;
  localparam logic [SampleW-1:0] S16Min = 16'h8000;

  // zero or oversize length falls back to the full block
  function automatic logic [LenW-1:0] eff_length(input logic [LenW-1:0] len);
    logic [LenW-1:0] l;
    l = len;
    if (l == '0 || l > MaxBlock) l = MaxBlock;
    if (l > PosSpan) l = PosSpan;
    return l;
  endfunction

endpackage

// ----- design/msc_stream_if.sv -----
// Interfaces: valid/ready channels for conversion words and sample words.
interface msc_in_if;
  import msc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] first_byte;
  logic [ByteW-1:0] second_byte;

  modport source (output valid, first_byte, second_byte, input ready);
  modport sink   (input valid, first_byte, second_byte, output ready);
endinterface

interface msc_out_if;
  import msc_pkg::*;
  logic               valid;
  logic               ready;
  logic [BufW-1:0]    buffer_index;
  logic [PosW-1:0]    write_offset;
  logic [SampleW-1:0] sample_word;
  logic               buffer_done;

  modport source (output valid, buffer_index, write_offset, sample_word, buffer_done,
                  input ready);
  modport sink   (input valid, buffer_index, write_offset, sample_word, buffer_done,
                  output ready);
endinterface

// ----- design/msc_sample_conv.sv -----
// Sample conversion: code assembly, offset removal, scaling and saturation.
module msc_sample_conv import msc_pkg::*; (
  input  logic               mode_i,
  input  logic [ByteW-1:0]   first_byte_i,
  input  logic [ByteW-1:0]   second_byte_i,
  output logic [SampleW-1:0] sample_o
);

  logic [7:0]         code8;
  logic [11:0]        code12;
  logic signed [7:0]  diff8;
  logic signed [11:0] diff12;
  logic [ByteW-1:0]   byte8;

  assign code8  = {first_byte_i[6:0], second_byte_i[7]};
  assign code12 = {first_byte_i[6:0], second_byte_i[7:3]};

  // removing mid-scale is just an inversion of the code's top bit
  assign diff8  = $signed({~code8[7], code8[6:0]});
  assign diff12 = $signed({~code12[11], code12[10:0]});

  always_comb begin
    if (diff8 > Sat8Hi) begin
      byte8 = U8Max;
    end else if (diff8 < Sat8Lo) begin
      byte8 = U8Min;
    end else begin
      // times four, then re-bias by 128
      byte8 = {~diff8[5], diff8[4:0], 2'b00};
    end

    if (!mode_i) begin
      sample_o = {8'h00, byte8};
    end else if (diff12 > Sat12Hi) begin
      sample_o = S16Max;
    end else if (diff12 < Sat12Lo) begin
      sample_o = S16Min;
    end else begin
      sample_o = {diff12[9:0], 6'b000000};
    end
  end

endmodule

// ----- design/mic_sample_capture_triple_buffer.sv -----
// Top level: microphone sample capture with rotating three-buffer addressing.
//
//  channel | dir | payload                                              | handshake
//  in_i    | in  | first_byte, second_byte                              | valid/ready
//  out_o   | out | buffer_index, write_offset, sample_word, buffer_done | valid/ready
//  cfg     | in  | cfg_idx_i, cfg_data_i                                | cfg_we_i
//
// One word in per cycle; its result appears in the output register the cycle after.
// Throughput is set by the output register: ready stays high while it is empty or
// being drained, so a stalled sink holds one result and the next word waits.
// Reset clears position, buffer index, output valid and the registers
// (sample mode 0, block length 4096).
`include "assert_macros.svh"

module mic_sample_capture_triple_buffer import msc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [LenW-1:0]     cfg_data_i,
  msc_in_if.sink              in_i,
  msc_out_if.source           out_o
);

  logic               mode_q;
  logic [LenW-1:0]    blk_len_q;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [BufW-1:0]    buf_q, buf_d;

  logic               out_valid_q;
  logic [BufW-1:0]    out_buf_q;
  logic [PosW-1:0]    out_off_q;
  logic [SampleW-1:0] out_sample_q;
  logic               out_done_q;

  logic               in_acc;
  logic               done;
  logic [LenW-1:0]    eff_len;
  logic [SampleW-1:0] sample;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  msc_sample_conv u_conv (
    .mode_i        (mode_q),
    .first_byte_i  (in_i.first_byte),
    .second_byte_i (in_i.second_byte),
    .sample_o      (sample)
  );

  assign eff_len = eff_length(blk_len_q);
  assign done    = ({1'b0, pos_q} + LenW'(1)) >= eff_len;

  always_comb begin
    pos_d = pos_q;
    buf_d = buf_q;
    if (in_acc) begin
      if (done) begin
        pos_d = '0;
        buf_d = (buf_q >= LastBuf) ? '0 : buf_q + BufW'(1);
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      blk_len_q <= MaxBlock;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSampleMode:  mode_q    <= cfg_data_i[0];
        CfgBlockLength: blk_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      buf_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      buf_q <= buf_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result word; loaded only on accept
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_buf_q    <= buf_q;
      out_off_q    <= pos_q;
      out_sample_q <= sample;
      out_done_q   <= done;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.buffer_index = out_buf_q;
  assign out_o.write_offset = out_off_q;
  assign out_o.sample_word  = out_sample_q;
  assign out_o.buffer_done  = out_done_q;

  `ASSERT_NEVER(a_buf_idx_range, clk_i, rst_ni, out_valid_q && out_buf_q == 2'd3, "buffer index three on output")
  `ASSERT_CLK(a_pos_wrap, clk_i, rst_ni, in_acc && done |=> pos_q == '0, "position not cleared at buffer end")
  `ASSERT_CLK(a_pos_step, clk_i, rst_ni, in_acc && !done |=> pos_q == $past(pos_q) + PosW'(1), "position did not advance by one")
  `ASSERT_CLK(a_buf_hold, clk_i, rst_ni, !(in_acc && done) |=> $stable(buf_q), "buffer index moved without a finished buffer")

endmodule

// ----- bench/tb.sv -----
// Testbench for the microphone capture block: directed table, random phases, scoreboard.
module tb;
  import msc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ModeByte   = 1'b0;
  localparam logic ModeSigned = 1'b1;

  typedef enum logic [1:0] {DO_WORD, DO_MODE, DO_LEN} step_e;

  typedef struct packed {
    step_e              kind;
    logic [LenW-1:0]    arg;
    logic [ByteW-1:0]   b1;
    logic [ByteW-1:0]   b2;
    logic               typed;
    logic [SampleW-1:0] want;
  } step_t;

  typedef struct packed {
    logic [BufW-1:0]    buffer_index;
    logic [PosW-1:0]    write_offset;
    logic [SampleW-1:0] sample_word;
    logic               buffer_done;
  } capture_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [LenW-1:0]    cfg_data;

  msc_in_if  in_ch ();
  msc_out_if out_ch ();

  mic_sample_capture_triple_buffer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and register copies
  logic            mode_q;
  logic [LenW-1:0] len_q;
  logic [PosW-1:0] pos_q;
  logic [BufW-1:0] buf_q;

  capture_t pending_captures [$];
  int       errors    = 0;
  int       idle_pct  = 0;
  bit       calm      = 1'b0;
  bit       hold_req  = 1'b0;

  // extremes, mid-scale and saturation edges carry their sample; the rest go to the predictor
  step_t directed_steps [$] = '{
    '{DO_WORD, 13'd0, 8'h00, 8'h00, 1'b1, 16'h0000},
    '{DO_WORD, 13'd0, 8'hFF, 8'hFF, 1'b1, 16'h00FF},
    '{DO_WORD, 13'd0, 8'h40, 8'h00, 1'b1, 16'h0080},
    '{DO_WORD, 13'd0, 8'h40, 8'h80, 1'b1, 16'h0084},
    '{DO_WORD, 13'd0, 8'h3F, 8'h80, 1'b1, 16'h007C},
    '{DO_WORD, 13'd0, 8'hC0, 8'h7F, 1'b1, 16'h0080},
    '{DO_WORD, 13'd0, 8'h4F, 8'h80, 1'b1, 16'h00FC},
    '{DO_WORD, 13'd0, 8'h50, 8'h00, 1'b1, 16'h00FF},
    '{DO_WORD, 13'd0, 8'h30, 8'h00, 1'b1, 16'h0000},
    '{DO_WORD, 13'd0, 8'h30, 8'h80, 1'b1, 16'h0004},
    // length dropped below the current position: next word closes the buffer
    '{DO_LEN,  13'd5, 8'h00, 8'h00, 1'b0, 16'h0000},
    '{DO_WORD, 13'd0, 8'h12, 8'h34, 1'b0, 16'h0000},
    '{DO_MODE, LenW'(ModeSigned), 8'h00, 8'h00, 1'b0, 16'h0000},
    '{DO_LEN,  13'd1, 8'h00, 8'h00, 1'b0, 16'h0000},
    '{DO_WORD, 13'd0, 8'h00, 8'h00, 1'b1, 16'h8000},
    '{DO_WORD, 13'd0, 8'h7F, 8'hF8, 1'b1, 16'h7FFF},
    '{DO_WORD, 13'd0, 8'h40, 8'h00, 1'b1, 16'h0000},
    '{DO_WORD, 13'd0, 8'h40, 8'h08, 1'b1, 16'h0040},
    '{DO_WORD, 13'd0, 8'h3F, 8'hF8, 1'b1, 16'hFFC0},
    '{DO_WORD, 13'd0, 8'hC0, 8'h07, 1'b1, 16'h0000},
    '{DO_WORD, 13'd0, 8'h4F, 8'hF8, 1'b1, 16'h7FC0},
    '{DO_WORD, 13'd0, 8'h50, 8'h00, 1'b1, 16'h7FFF},
    '{DO_WORD, 13'd0, 8'h30, 8'h00, 1'b1, 16'h8000},
    '{DO_WORD, 13'd0, 8'h30, 8'h08, 1'b1, 16'h8040},
    // zero and oversize lengths fall back to the full block
    '{DO_LEN,  13'd0, 8'h00, 8'h00, 1'b0, 16'h0000},
    '{DO_WORD, 13'd0, 8'h5A, 8'hC3, 1'b0, 16'h0000},
    '{DO_LEN,  13'd8191, 8'h00, 8'h00, 1'b0, 16'h0000},
    '{DO_WORD, 13'd0, 8'h25, 8'h9E, 1'b0, 16'h0000},
    '{DO_LEN,  13'd4097, 8'h00, 8'h00, 1'b0, 16'h0000},
    '{DO_WORD, 13'd0, 8'hA5, 8'h3C, 1'b0, 16'h0000},
    '{DO_LEN,  13'd2, 8'h00, 8'h00, 1'b0, 16'h0000},
    '{DO_WORD, 13'd0, 8'h81, 8'h00, 1'b0, 16'h0000}
  };

  function automatic capture_t capture_sample(input logic [ByteW-1:0] b1, b2);
    capture_t r;
    int code, v, span;
    span = int'(len_q);
    if (span == 0 || span > 4096) span = 4096;
    if (mode_q == ModeByte) begin
      code = int'({b1[6:0], b2[7]});
      v = (code - 128) * 4;
      if (v > 127) v = 127;
      if (v < -128) v = -128;
      r.sample_word = SampleW'(v + 128);
    end else begin
      code = int'({b1[6:0], b2[7:3]});
      v = (code - 2048) * 64;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      r.sample_word = SampleW'(v);
    end
    r.buffer_index = buf_q;
    r.write_offset = pos_q;
    r.buffer_done  = (int'(pos_q) + 1 >= span);
    if (r.buffer_done) begin
      pos_q = '0;
      buf_q = (buf_q >= LastBuf) ? '0 : buf_q + 1'b1;
    end else begin
      pos_q = pos_q + 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got, want);
    errors++;
    if (errors <= 50) $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic send_word(input logic [ByteW-1:0] b1, b2, input logic typed = 1'b0,
                           input logic [SampleW-1:0] fixed = '0);
    capture_t due;
    if (!calm && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.first_byte  <= b1;
    in_ch.second_byte <= b2;
    do @(posedge clk); while (!in_ch.ready);
    due = capture_sample(b1, b2);
    if (typed) due.sample_word = fixed;
    pending_captures.push_back(due);
  endtask

  // stop offering and wait for every outstanding sample word
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_captures.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [LenW-1:0] data);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgSampleMode) mode_q = data[0];
    else len_q = data;
  endtask

  always @(posedge clk) begin : check_results
    capture_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.buffer_index, out_ch.write_offset, out_ch.sample_word,
              out_ch.buffer_done};
      if (pending_captures.size() == 0) begin
        report_mismatch("unexpected sample word", got, 0);
      end else begin
        want = pending_captures.pop_front();
        if (got.buffer_index !== want.buffer_index)
          report_mismatch("buffer_index", got.buffer_index, want.buffer_index);
        if (got.write_offset !== want.write_offset)
          report_mismatch("write_offset", got.write_offset, want.write_offset);
        if (got.sample_word !== want.sample_word)
          report_mismatch("sample_word", got.sample_word, want.sample_word);
        if (got.buffer_done !== want.buffer_done)
          report_mismatch("buffer_done", got.buffer_done, want.buffer_done);
      end
    end
  end

  // output side: random stall bursts, plus one long hold when asked
  initial begin : sink
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 39;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(99) < idle_pct) begin
        stall_left = $urandom_range(3, 0);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : limit
    #5_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin : stimulus
    step_t           row;
    int              n, pick;
    logic [LenW-1:0] len;
    in_ch.valid       <= 1'b0;
    in_ch.first_byte  <= '0;
    in_ch.second_byte <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CfgSampleMode;
    cfg_data <= '0;
    mode_q = ModeByte;
    len_q  = MaxBlock;
    pos_q  = '0;
    buf_q  = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 30;
    foreach (directed_steps[i]) begin
      row = directed_steps[i];
      case (row.kind)
        DO_MODE: write_reg(CfgSampleMode, row.arg);
        DO_LEN:  write_reg(CfgBlockLength, row.arg);
        default: send_word(row.b1, row.b2, row.typed, row.want);
      endcase
    end

    for (int ph = 0; ph < 12; ph++) begin
      pick = $urandom_range(99);
      if (pick < 60) len = LenW'($urandom_range(16, 1));
      else if (pick < 80) len = LenW'($urandom_range(300, 17));
      else if (pick < 87) len = '0;
      else if (pick < 94) len = LenW'($urandom_range(8191, 4097));
      else len = MaxBlock;
      write_reg(CfgSampleMode, LenW'($urandom_range(1)));
      write_reg(CfgBlockLength, len);
      case ($urandom_range(2))
        0: idle_pct = 0;
        1: idle_pct = 20;
        default: idle_pct = 50;
      endcase
      // sink holds off while words keep coming, so the input backs up
      if (ph == 2) hold_req = 1'b1;
      n = $urandom_range(160, 60);
      repeat (n) send_word(ByteW'($urandom_range(255)), ByteW'($urandom_range(255)));
    end

    // closing stretch without idling: two full buffers from offset zero
    calm = 1'b1;
    write_reg(CfgBlockLength, 13'd1);
    send_word(ByteW'($urandom_range(255)), ByteW'($urandom_range(255)));
    write_reg(CfgSampleMode, LenW'($urandom_range(1)));
    write_reg(CfgBlockLength, 13'd320);
    repeat (640) send_word(ByteW'($urandom_range(255)), ByteW'($urandom_range(255)));
    drain();

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
